// ===== src/assert_macros.svh =====
// Assertion macros shared by the shortest path block.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/spd_pkg.sv =====
// Types and constants of the shortest path block.
// Depends on nothing.
`default_nettype none
package spd_pkg;
	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES = 1024;
	localparam int WEIGHT_BITS = 16;
	localparam int VB = $clog2(MAX_VERTICES);
	localparam int EB = $clog2(MAX_EDGES);
	localparam int DIST_BITS = 22;
	localparam int WIDE_BITS = VB + WEIGHT_BITS + 1;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_RUN = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] edge_from;
		logic [5:0] edge_to;
		logic [15:0] edge_weight;
		logic [5:0] start_vertex;
	} in_word_t;

	typedef struct packed {
		logic [5:0] vertex;
		logic [21:0] distance;
		logic reachable;
		logic [5:0] predecessor;
		logic has_predecessor;
		logic [1:0] status;
		logic last;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN_RD, S_SCAN, S_EDGE_RD, S_EDGE, S_RELAX,
		S_OUT_RD, S_OUT
	} state_t;
endpackage
`default_nettype wire

// ===== src/shortest_path_dijkstra.sv =====
// Top level of the shortest path block: sequencer, edge table, vertex stores.
// Depends on spd_pkg and assert_macros.svh.
`default_nettype none
// Usage: write vertex_count through cfg_we/cfg_data while idle (reset 64,
// saturates at 64). Issue a word on start while busy is low. Add and clear
// words give no result; an add to a full table gives one error word. A run
// gives one error word if the start is out of range, otherwise one result
// word per vertex in index order, each strobed by result_valid for one
// cycle, last marking the final one.
// A run first clears the flags of all n vertices in its init phase; each
// round that settles a vertex then does a minimum scan of the n vertices
// (one a cycle through the shared comparator, after a read step), then a
// sweep of all E stored edges (a read and a test per edge, plus a relax
// step for each relaxation), then one closing step; a final scan finds
// nothing left, then the output phase reads each vertex's stores and
// gives its result word.
// busy is high while a run with a valid start proceeds, and low for other
// words. The receiver cannot stall; results are always taken. Reset empties
// the edge table and returns the sequencer to idle.
`include "assert_macros.svh"
module shortest_path_dijkstra (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire spd_pkg::in_word_t in_word,
	output logic busy,
	input  wire logic cfg_we,
	input  wire logic [6:0] cfg_data,
	output logic result_valid,
	output spd_pkg::out_word_t result
);
	import spd_pkg::*;

	state_t state_q, state_d;
	logic [6:0] vcount_q;
	logic [EB:0] ecount_q;
	logic [VB-1:0] n1_q;          // vertex count minus one
	logic [VB-1:0] start_q, idx_q, best_q;
	logic best_ok_q, found_q;
	logic [EB:0] eidx_q;
	logic [DIST_BITS-1:0] bestd_q;
	logic [MAX_VERTICES-1:0] settled_q, tent_q;

	// Memories
	logic [27:0] edge_mem [MAX_EDGES];
	logic [27:0] edge_rd_q;
	logic [DIST_BITS-1:0] dist_mem [MAX_VERTICES];
	logic [VB-1:0] pred_mem [MAX_VERTICES];
	logic [DIST_BITS-1:0] dist_rd_q;
	logic [VB-1:0] pred_rd_q;
	logic [VB-1:0] rd_addr;
	logic dist_we;
	logic [VB-1:0] dist_wa;
	logic [DIST_BITS-1:0] dist_wd;

	logic accept;
	logic [6:0] n_eff;
	logic [VB-1:0] e_src, e_dst;
	logic [WEIGHT_BITS-1:0] e_wt;
	logic [DIST_BITS-1:0] nd;
	logic e_use;
	out_word_t res_d;
	logic res_v_d;

	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign n_eff = (vcount_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_q;
	assign e_src = edge_rd_q[27 -: VB];
	assign e_dst = edge_rd_q[27-VB -: VB];
	assign e_wt = edge_rd_q[WEIGHT_BITS-1:0];
	// shared adder: candidate distance through the settled vertex
	assign nd = bestd_q + DIST_BITS'(e_wt);
	assign e_use = (e_src == best_q) && ({1'b0, e_src} <= {1'b0, n1_q})
		&& (e_dst <= n1_q) && !settled_q[e_dst];

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// Pick the read address of the vertex stores; the scan reads one ahead
	always_comb begin
		case (state_q)
			S_SCAN: rd_addr = idx_q + 1'b1;
			S_EDGE: rd_addr = e_dst;
			default: rd_addr = idx_q;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept && in_word.func == FUNC_RUN && n_eff != 7'd0
				&& {1'b0, in_word.start_vertex} < n_eff) state_d = S_INIT;
			S_INIT: if (idx_q == n1_q) state_d = S_SCAN_RD;
			S_SCAN_RD: state_d = S_SCAN;
			S_SCAN: if (idx_q == n1_q) state_d = S_EDGE_RD;
			S_EDGE_RD: begin
				if (!found_q) state_d = S_OUT_RD;
				else if (eidx_q == ecount_q) state_d = S_SCAN_RD;
				else state_d = S_EDGE;
			end
			S_EDGE: state_d = (e_use) ? S_RELAX : S_EDGE_RD;
			S_RELAX: state_d = S_EDGE_RD;
			S_OUT_RD: state_d = S_OUT;
			S_OUT: state_d = (idx_q == n1_q) ? S_IDLE : S_OUT_RD;
			default: state_d = S_IDLE;
		endcase
	end

	// Vertex store write select
	always_comb begin
		dist_we = 1'b0;
		dist_wa = e_dst;
		dist_wd = nd;
		if (state_q == S_RELAX && (!tent_q[e_dst] || nd < dist_rd_q))
			dist_we = 1'b1;
		if (state_q == S_INIT && idx_q == start_q) begin
			dist_we = 1'b1;
			dist_wa = start_q;
			dist_wd = '0;
		end
	end

	// Build the next result word
	always_comb begin
		res_v_d = 1'b0;
		res_d = '0;
		case (state_q)
			S_IDLE: if (accept) begin
				if (in_word.func == FUNC_ADD && ecount_q == (EB+1)'(MAX_EDGES)) begin
					res_v_d = 1'b1;
					res_d.status = ST_FULL;
					res_d.last = 1'b1;
				end
				if (in_word.func == FUNC_RUN && (n_eff == 7'd0
					|| {1'b0, in_word.start_vertex} >= n_eff)) begin
					res_v_d = 1'b1;
					res_d.status = ST_START;
					res_d.last = 1'b1;
				end
			end
			S_OUT: begin
				res_v_d = 1'b1;
				res_d.vertex = idx_q;
				res_d.reachable = settled_q[idx_q];
				res_d.distance = settled_q[idx_q] ? dist_rd_q : '0;
				res_d.has_predecessor = settled_q[idx_q] && idx_q != start_q;
				res_d.predecessor = (settled_q[idx_q] && idx_q != start_q)
					? pred_rd_q : '0;
				res_d.last = (idx_q == n1_q);
			end
			default: ;
		endcase
	end

	// Memories: edge table and vertex stores
	always_ff @(posedge clk) begin
		if (accept && in_word.func == FUNC_ADD && ecount_q != (EB+1)'(MAX_EDGES))
			edge_mem[ecount_q[EB-1:0]] <= {in_word.edge_from, in_word.edge_to,
				in_word.edge_weight[WEIGHT_BITS-1:0]};
		// hold the fetched edge through its relax cycle
		if (state_q == S_EDGE_RD) edge_rd_q <= edge_mem[eidx_q[EB-1:0]];
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
			pred_mem[dist_wa] <= best_q;
		end
		dist_rd_q <= dist_mem[rd_addr];
		pred_rd_q <= pred_mem[rd_addr];
	end

	// Control registers and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= 7'd64;
			ecount_q <= '0;
			n1_q <= '0; start_q <= '0; idx_q <= '0; best_q <= '0;
			best_ok_q <= 1'b0; found_q <= 1'b0; eidx_q <= '0; bestd_q <= '0;
			settled_q <= '0; tent_q <= '0;
			result_valid <= 1'b0;
			result <= '0;
		end else begin
			result_valid <= res_v_d;
			result <= res_d;
			if (cfg_we) vcount_q <= cfg_data;
			case (state_q)
				S_IDLE: if (accept) begin
					n1_q <= VB'(n_eff - 7'd1);
					start_q <= in_word.start_vertex;
					idx_q <= '0;
					case (in_word.func)
						FUNC_ADD: begin
							if (ecount_q != (EB+1)'(MAX_EDGES)) ecount_q <= ecount_q + 1'b1;
						end
						FUNC_CLEAR: ecount_q <= '0;
						default: ;
					endcase
				end
				S_INIT: begin
					settled_q[idx_q] <= 1'b0;
					tent_q[idx_q] <= (idx_q == start_q);
					if (idx_q == n1_q) idx_q <= '0; else idx_q <= idx_q + 1'b1;
					best_ok_q <= 1'b0;
				end
				S_SCAN_RD: best_ok_q <= 1'b0;
				S_SCAN: begin
					// shared compare: keep strictly smaller, lowest index wins
					if (tent_q[idx_q] && !settled_q[idx_q]
						&& (!best_ok_q || dist_rd_q < bestd_q)) begin
						best_ok_q <= 1'b1;
						best_q <= idx_q;
						bestd_q <= dist_rd_q;
					end
					if (idx_q == n1_q) begin
						idx_q <= '0;
						eidx_q <= '0;
						found_q <= best_ok_q || (tent_q[idx_q] && !settled_q[idx_q]);
						if (tent_q[idx_q] && !settled_q[idx_q]
							&& (!best_ok_q || dist_rd_q < bestd_q))
							settled_q[idx_q] <= 1'b1;
						else if (best_ok_q) settled_q[best_q] <= 1'b1;
					end else idx_q <= idx_q + 1'b1;
				end
				S_EDGE_RD: if (found_q && eidx_q != ecount_q) eidx_q <= eidx_q + 1'b1;
				S_RELAX: if (dist_we) tent_q[e_dst] <= 1'b1;
				S_OUT: idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	`ASSERT_NEXT(a_ready_idle, clk, arst_n, state_q == S_OUT && idx_q == n1_q, !busy)
	`ASSERT_IMPL(a_last_status, clk, arst_n, result_valid && result.status != ST_OK,
		result.last)
	`ASSERT_IMPL(a_count_max, clk, arst_n, 1'b1, ecount_q <= (EB+1)'(MAX_EDGES))
endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for shortest_path_dijkstra: drives edge, clear and run words,
// predicts every result word with its own shortest path model, checks them.
// Depends on spd_pkg and the shortest_path_dijkstra RTL.
`timescale 1ns / 1ps

// Path predictor and store of expected result words.
class path_scoreboard;
	logic [5:0] edge_src [1024];
	logic [5:0] edge_dst [1024];
	logic [15:0] edge_wt [1024];
	int unsigned edge_total;
	int unsigned vertex_limit;
	spd_pkg::out_word_t pending[$];
	int unsigned fail_count;

	function new();
		edge_total = 0;
		vertex_limit = 64;
		fail_count = 0;
	endfunction

	function void set_vertex_count(logic [6:0] value);
		vertex_limit = value;
	endfunction

	function void push_error(logic [1:0] code);
		spd_pkg::out_word_t w;
		w = '0;
		w.status = code;
		w.last = 1'b1;
		pending.push_back(w);
	endfunction

	// Compute expected words for one accepted input word.
	function void note_input(spd_pkg::in_word_t iw);
		int unsigned n;
		int unsigned best;
		longint unsigned path_len [64];
		logic [5:0] pred [64];
		bit settled [64];
		bit seen [64];
		longint unsigned nd;
		spd_pkg::out_word_t w;
		n = (vertex_limit > 64) ? 64 : vertex_limit;
		case (iw.func)
			spd_pkg::FUNC_ADD: begin
				if (edge_total >= 1024) begin
					push_error(spd_pkg::ST_FULL);
				end else begin
					edge_src[edge_total] = iw.edge_from;
					edge_dst[edge_total] = iw.edge_to;
					edge_wt[edge_total] = iw.edge_weight;
					edge_total++;
				end
			end
			spd_pkg::FUNC_CLEAR: edge_total = 0;
			spd_pkg::FUNC_RUN: begin
				if (iw.start_vertex >= n) begin
					push_error(spd_pkg::ST_START);
				end else begin
					for (int i = 0; i < 64; i++) begin
						path_len[i] = 0;
						pred[i] = 0;
						settled[i] = 0;
						seen[i] = 0;
					end
					seen[iw.start_vertex] = 1;
					for (int r = 0; r < n; r++) begin
						best = n;
						for (int i = 0; i < n; i++)
							if (seen[i] && !settled[i]
								&& (best == n || path_len[i] < path_len[best]))
								best = i;
						if (best == n)
							break;
						settled[best] = 1;
						for (int k = 0; k < edge_total; k++) begin
							if (edge_src[k] != best || edge_dst[k] >= n)
								continue;
							if (settled[edge_dst[k]])
								continue;
							nd = path_len[best] + edge_wt[k];
							if (!seen[edge_dst[k]] || nd < path_len[edge_dst[k]]) begin
								path_len[edge_dst[k]] = nd;
								pred[edge_dst[k]] = best[5:0];
								seen[edge_dst[k]] = 1;
							end
						end
					end
					for (int i = 0; i < n; i++) begin
						w = '0;
						w.vertex = i[5:0];
						if (settled[i]) begin
							w.distance = path_len[i][21:0];
							w.reachable = 1'b1;
							if (i != iw.start_vertex) begin
								w.predecessor = pred[i];
								w.has_predecessor = 1'b1;
							end
						end
						w.last = (i + 1 == n);
						pending.push_back(w);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Compare one result word with the oldest expectation.
	function void check_result(spd_pkg::out_word_t got);
		spd_pkg::out_word_t exp_w;
		if (pending.size() == 0) begin
			$error("unexpected result word %h", got);
			fail_count++;
			return;
		end
		exp_w = pending.pop_front();
		if (got.vertex !== exp_w.vertex) begin
			$error("vertex: expected %0d actual %0d", exp_w.vertex, got.vertex);
			fail_count++;
		end
		if (got.distance !== exp_w.distance) begin
			$error("distance: expected %0d actual %0d", exp_w.distance, got.distance);
			fail_count++;
		end
		if (got.reachable !== exp_w.reachable) begin
			$error("reachable: expected %0d actual %0d", exp_w.reachable, got.reachable);
			fail_count++;
		end
		if (got.predecessor !== exp_w.predecessor) begin
			$error("predecessor: expected %0d actual %0d", exp_w.predecessor,
				got.predecessor);
			fail_count++;
		end
		if (got.has_predecessor !== exp_w.has_predecessor) begin
			$error("has_predecessor: expected %0d actual %0d", exp_w.has_predecessor,
				got.has_predecessor);
			fail_count++;
		end
		if (got.status !== exp_w.status) begin
			$error("status: expected %0d actual %0d", exp_w.status, got.status);
			fail_count++;
		end
		if (got.last !== exp_w.last) begin
			$error("last: expected %0d actual %0d", exp_w.last, got.last);
			fail_count++;
		end
	endfunction
endclass

module testbench;
	import spd_pkg::*;

	localparam int STALL_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic start;
	in_word_t in_word;
	logic busy;
	logic cfg_we;
	logic [6:0] cfg_data;
	logic result_valid;
	out_word_t result;

	path_scoreboard board;
	int unsigned idle_pct;
	int unsigned quiet_cycles;
	int unsigned edge_span;

	shortest_path_dijkstra DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.in_word(in_word),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Check results and watch for a stalled run.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid)
				board.check_result(result);
			if (result_valid || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("shortest_path_dijkstra verification failed");
				$finish;
			end
		end
	end

	// Hand one word to the block and note it once accepted; start stays
	// high for a following word and is dropped by the idle loop or drain.
	task automatic send_word(in_word_t w);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		in_word <= w;
		do
			@(posedge clk);
		while (busy);
		board.note_input(w);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (board.pending.size() != 0 || busy)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_vertex_count(logic [6:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_vertex_count(value);
	endtask

	task automatic add_edge(logic [5:0] src, logic [5:0] dst, logic [15:0] wt);
		in_word_t w;
		w = in_word_t'($urandom);
		w.func = FUNC_ADD;
		w.edge_from = src;
		w.edge_to = dst;
		w.edge_weight = wt;
		send_word(w);
	endtask

	task automatic run_from(logic [5:0] src);
		in_word_t w;
		w = in_word_t'($urandom);
		w.func = FUNC_RUN;
		w.start_vertex = src;
		send_word(w);
	endtask

	task automatic clear_edges();
		in_word_t w;
		w = in_word_t'($urandom);
		w.func = FUNC_CLEAR;
		send_word(w);
	endtask

	// Random words: mostly edges within edge_span, runs, clears, unused funcs.
	task automatic random_words(int unsigned count);
		in_word_t w;
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			w = in_word_t'({$urandom, $urandom});
			if (pick < 70) begin
				w.func = FUNC_ADD;
				if ($urandom_range(9) != 0) begin
					w.edge_from = 6'($urandom_range(edge_span - 1));
					w.edge_to = 6'($urandom_range(edge_span - 1));
				end
				if ($urandom_range(3) == 0)
					w.edge_weight = 16'($urandom_range(20));
			end else if (pick < 88) begin
				w.func = FUNC_RUN;
				if ($urandom_range(7) != 0)
					w.start_vertex = 6'($urandom_range(edge_span - 1));
			end else if (pick < 94) begin
				w.func = FUNC_CLEAR;
			end else begin
				w.func = 2'd3;
			end
			send_word(w);
		end
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		cfg_we = 1'b0;
		cfg_data = 7'd64;
		idle_pct = 34;
		quiet_cycles = 0;
		edge_span = 8;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: small graph, ties, parallel edge, self loop, extremes.
		write_vertex_count(7'd6);
		add_edge(6'd0, 6'd1, 16'd4);
		add_edge(6'd0, 6'd2, 16'd4);
		add_edge(6'd1, 6'd3, 16'd0);
		add_edge(6'd2, 6'd3, 16'd0);
		add_edge(6'd1, 6'd1, 16'd7);
		add_edge(6'd0, 6'd1, 16'd2);
		add_edge(6'd3, 6'd4, 16'hFFFF);
		add_edge(6'd4, 6'd63, 16'd1);
		add_edge(6'd63, 6'd5, 16'd1);
		run_from(6'd0);
		run_from(6'd5);
		run_from(6'd6);
		run_from(6'd63);
		write_vertex_count(7'd0);
		run_from(6'd0);
		write_vertex_count(7'd127);
		run_from(6'd63);
		clear_edges();
		write_vertex_count(7'd64);
		for (int i = 0; i < 63; i++)
			add_edge(i[5:0], 6'(i + 1), 16'hFFFF);
		run_from(6'd0);
		write_vertex_count(7'd1);
		run_from(6'd0);
		clear_edges();

		// Random phases with different vertex counts and idling.
		idle_pct = 34;
		write_vertex_count(7'd8);
		random_words(12);
		wait_drained();
		idle_pct = 63;
		write_vertex_count(7'd64);
		edge_span = 64;
		random_words(6);
		edge_span = 5;
		write_vertex_count(7'd5);
		random_words(6);
		idle_pct = 0;
		edge_span = 16;
		write_vertex_count(7'd16);
		random_words(8);

		wait_drained();
		if (board.fail_count == 0)
			$display("shortest_path_dijkstra verification clean");
		else
			$display("shortest_path_dijkstra verification failed");
		$finish;
	end
endmodule
